FILE: rtl/hex_rle_bitmap_blitter_defines.svh
// Assertion macros for the top level of the run-length bitmap blitter.
`ifndef HEX_RLE_BITMAP_BLITTER_DEFINES_SVH
`define HEX_RLE_BITMAP_BLITTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define HRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define HRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/hrb_pkg.sv
// Shared constants, codes and record types of the run-length bitmap blitter.
package hrb_pkg;

  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int COL_W    = $clog2(MAX_SIDE);
  localparam int ROW_W    = 13;
  localparam int POS_W    = ROW_W + SIDE_W + 1;
  localparam int COORD_W  = 13;

  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // Input item kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_STARTED = 2'd0;
  localparam logic [1:0] ST_CHAR    = 2'd1;
  localparam logic [1:0] ST_PIXEL   = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd3;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
  } cfg_t;

  // One classified item on its way from the front end to the blend stage.
  typedef struct packed {
    logic [1:0]         status;
    logic               write_enable;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [31:0]        color;
    logic               blend;
    logic [23:0]        background;
    logic               run_pending;
    logic [COORD_W-1:0] next_x;
    logic [COORD_W-1:0] next_y;
    logic               next_needs_background;
    logic               done_res;
  } front_rec_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               write_enable;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [31:0]        pixel_color;
    logic               run_pending;
    logic [COORD_W-1:0] next_x;
    logic [COORD_W-1:0] next_y;
    logic               next_needs_background;
    logic               done_res;
  } result_t;

endpackage

FILE: rtl/hrb_front.sv
// Front end: text parser, run counters and image position tracking.
module hrb_front
  import hrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [1:0]  kind,
  input  logic [7:0]  text_char,
  input  logic [23:0] background,
  output front_rec_t  rec
);

  typedef enum logic [1:0] {PH_START, PH_COUNT, PH_COLOR} phase_t;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        return {1'b0, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
        return {1'b0, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
        return {1'b0, d[3:0]};
      end
      return 5'h10;
    end
  endfunction

  phase_t           phase_r, phase_nxt;
  logic [2:0]       dc_r, dc_nxt;
  logic [31:0]      ca_r, ca_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             stop_r, stop_nxt;
  logic [31:0]      rc_r, rc_nxt;
  logic [7:0]       rl_r, rl_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             fin_r, fin_nxt;

  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [POS_W-1:0]  rw, pos_cur, pos_new, total;
  logic [POS_W-1:0]  left_cur;
  logic [SIDE_W:0]   col_inc;
  logic              wrap;
  logic [4:0]        hv;
  logic [3:0]        digit;
  logic [2:0]        dcw;
  logic [31:0]       caw, ca_new;
  logic [7:0]        cntw;
  logic [7:0]        alpha, alpha_nxt;

  // Width and height registers act clamped to one through MAX_SIDE.
  always_comb begin
    if (32'(cfg.width) > MAX_SIDE) begin
      w_eff = SIDE_W'(MAX_SIDE);
    end else if (cfg.width == '0) begin
      w_eff = SIDE_W'(1);
    end else begin
      w_eff = SIDE_W'(cfg.width);
    end
    if (32'(cfg.height) > MAX_SIDE) begin
      h_eff = SIDE_W'(MAX_SIDE);
    end else if (cfg.height == '0) begin
      h_eff = SIDE_W'(1);
    end else begin
      h_eff = SIDE_W'(cfg.height);
    end
  end

  // Linear position in the image, before and after a pixel step.
  assign rw       = POS_W'(row_r) * POS_W'(w_eff);
  assign pos_cur  = rw + POS_W'(col_r);
  assign total    = POS_W'(w_eff) * POS_W'(h_eff);
  assign left_cur = (pos_cur >= total) ? '0 : total - pos_cur;
  assign col_inc  = (SIDE_W+1)'(col_r) + (SIDE_W+1)'(1);
  assign wrap     = col_inc >= (SIDE_W+1)'(w_eff);
  assign pos_new  = wrap ? rw + POS_W'(w_eff) : pos_cur + POS_W'(1);

  assign hv    = hex_value(text_char);
  assign digit = hv[4] ? 4'h0 : hv[3:0];
  assign alpha = rc_r[31:24];

  always_comb begin
    phase_nxt = phase_r;
    dc_nxt    = dc_r;
    ca_nxt    = ca_r;
    cnt_nxt   = cnt_r;
    stop_nxt  = stop_r;
    rc_nxt    = rc_r;
    rl_nxt    = rl_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    fin_nxt   = fin_r;
    dcw       = dc_r;
    caw       = ca_r;
    cntw      = cnt_r;
    ca_new    = '0;
    rec       = '0;
    rec.status = ST_REJECT;

    if (kind == KIND_START) begin
      phase_nxt  = PH_START;
      dc_nxt     = '0;
      ca_nxt     = '0;
      cnt_nxt    = 8'd1;
      stop_nxt   = 1'b0;
      rc_nxt     = '0;
      rl_nxt     = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      fin_nxt    = 1'b0;
      rec.status = ST_STARTED;
    end else if (kind == KIND_CHAR) begin
      if (!fin_r && rl_r == '0) begin
        rec.status = ST_CHAR;
        if (text_char == CH_NUL) begin
          // The terminator drops any partial token and closes the image.
          phase_nxt = PH_START;
          dc_nxt    = '0;
          ca_nxt    = '0;
          cnt_nxt   = 8'd1;
          stop_nxt  = 1'b0;
          fin_nxt   = 1'b1;
        end else if (phase_r == PH_START && text_char == CH_TILDE) begin
          phase_nxt = PH_COUNT;
          dc_nxt    = '0;
          cnt_nxt   = '0;
          stop_nxt  = 1'b0;
        end else if (phase_r == PH_COUNT) begin
          if (!stop_r && !hv[4]) begin
            cnt_nxt = {cnt_r[3:0], hv[3:0]};
          end else begin
            stop_nxt = 1'b1;
          end
          if (dc_r == 3'd1) begin
            phase_nxt = PH_COLOR;
            dc_nxt    = '0;
            ca_nxt    = '0;
          end else begin
            dc_nxt = dc_r + 3'd1;
          end
        end else begin
          // A token without a count starts straight with its first color digit.
          if (phase_r == PH_START) begin
            cntw = 8'd1;
            dcw  = '0;
            caw  = '0;
          end
          ca_new = {caw[27:0], digit};
          if (dcw == 3'd7) begin
            rc_nxt    = ca_new;
            rl_nxt    = (POS_W'(cntw) < left_cur) ? cntw : left_cur[7:0];
            if (left_cur == '0) begin
              fin_nxt = 1'b1;
            end
            phase_nxt = PH_START;
            dc_nxt    = '0;
            ca_nxt    = '0;
            cnt_nxt   = 8'd1;
            stop_nxt  = 1'b0;
          end else begin
            phase_nxt = PH_COLOR;
            dc_nxt    = dcw + 3'd1;
            ca_nxt    = ca_new;
            cnt_nxt   = cntw;
          end
        end
      end
    end else if (kind == KIND_STEP) begin
      if (rl_r != '0) begin
        rec.status  = ST_PIXEL;
        rec.pixel_x = COORD_W'(cfg.origin_x) + COORD_W'(col_r);
        rec.pixel_y = COORD_W'(cfg.origin_y) + COORD_W'(row_r);
        if (alpha == 8'hFF) begin
          rec.write_enable = 1'b1;
          rec.color        = rc_r;
        end else if (alpha != 8'h00) begin
          rec.write_enable = 1'b1;
          rec.blend        = 1'b1;
          rec.color        = rc_r;
          rec.background   = background;
        end
        if (wrap) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_inc[COL_W-1:0];
        end
        rl_nxt = rl_r - 8'd1;
        if (rl_r == 8'd1 && pos_new >= total) begin
          fin_nxt = 1'b1;
        end
      end
    end

    alpha_nxt                 = rc_nxt[31:24];
    rec.run_pending           = rl_nxt != '0;
    rec.next_x                = COORD_W'(cfg.origin_x) + COORD_W'(col_nxt);
    rec.next_y                = COORD_W'(cfg.origin_y) + COORD_W'(row_nxt);
    rec.next_needs_background = (rl_nxt != '0) && (alpha_nxt != 8'h00) &&
                                (alpha_nxt != 8'hFF);
    rec.done_res              = fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      dc_r    <= '0;
      ca_r    <= '0;
      cnt_r   <= 8'd1;
      stop_r  <= 1'b0;
      rc_r    <= '0;
      rl_r    <= '0;
      col_r   <= '0;
      row_r   <= '0;
      fin_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      dc_r    <= dc_nxt;
      ca_r    <= ca_nxt;
      cnt_r   <= cnt_nxt;
      stop_r  <= stop_nxt;
      rc_r    <= rc_nxt;
      rl_r    <= rl_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

FILE: rtl/hrb_mid_queue.sv
// Short queue of classified items between the front end and the blend stage.
module hrb_mid_queue
  import hrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  front_rec_t wr_data,
  output logic       q_full,
  input  logic       rd_en,
  output front_rec_t rd_data,
  output logic       q_empty
);

  front_rec_t        mem_r [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [MID_AW:0]   cnt_r, cnt_nxt;

  assign q_full  = cnt_r == (MID_AW+1)'(MID_DEPTH);
  assign q_empty = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + (MID_AW+1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - (MID_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + MID_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + MID_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/hrb_back.sv
// Back end: alpha blend pipeline and the result queue.
module hrb_back
  import hrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  front_rec_t mid_data,
  input  logic       mid_empty,
  output logic       mid_pop,
  output result_t    res,
  output logic       res_empty,
  input  logic       res_pop
);

  // x / 255 for x up to 255 * 255, without a divider.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    begin
      s = 17'(x) + 17'(x[15:8]) + 17'd1;
      return s[15:8];
    end
  endfunction

  front_rec_t  s1_rec_r;
  logic        s1_v_r;
  logic [15:0] prod_r [3];
  logic [15:0] prod_nxt [3];
  logic [7:0]  a, na;

  result_t           q_r [OUT_DEPTH];
  result_t           wr_res;
  logic [OUT_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_AW:0]   cnt_r, cnt_nxt;
  logic [OUT_AW+1:0] used;
  logic              q_wr, q_rd;

  // Pop the middle queue only when the result queue keeps a slot for it.
  assign used    = (OUT_AW+2)'(cnt_r) + (OUT_AW+2)'(s1_v_r);
  assign mid_pop = !mid_empty && (used < (OUT_AW+2)'(OUT_DEPTH));

  assign a  = mid_data.color[31:24];
  assign na = 8'hFF - a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = 16'(mid_data.color[8*i +: 8] * a) +
                    16'(mid_data.background[8*i +: 8] * na);
    end
  end

  always_comb begin
    wr_res.status                = s1_rec_r.status;
    wr_res.write_enable          = s1_rec_r.write_enable;
    wr_res.pixel_x               = s1_rec_r.pixel_x;
    wr_res.pixel_y               = s1_rec_r.pixel_y;
    wr_res.pixel_color           = s1_rec_r.blend ?
                                   {8'hFF, div255(prod_r[2]), div255(prod_r[1]),
                                    div255(prod_r[0])} : s1_rec_r.color;
    wr_res.run_pending           = s1_rec_r.run_pending;
    wr_res.next_x                = s1_rec_r.next_x;
    wr_res.next_y                = s1_rec_r.next_y;
    wr_res.next_needs_background = s1_rec_r.next_needs_background;
    wr_res.done_res              = s1_rec_r.done_res;
  end

  assign q_wr      = s1_v_r;
  assign q_rd      = res_pop && (cnt_r != '0);
  assign res_empty = cnt_r == '0;
  assign res       = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr && !q_rd) begin
      cnt_nxt = cnt_r + (OUT_AW+1)'(1);
    end else if (q_rd && !q_wr) begin
      cnt_nxt = cnt_r - (OUT_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      s1_v_r <= mid_pop;
      cnt_r  <= cnt_nxt;
      if (q_wr) begin
        wr_ptr_r <= wr_ptr_r + OUT_AW'(1);
      end
      if (q_rd) begin
        rd_ptr_r <= rd_ptr_r + OUT_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_rec_r <= mid_data;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (q_wr) begin
      q_r[wr_ptr_r] <= wr_res;
    end
  end

endmodule

FILE: rtl/hex_rle_bitmap_blitter.sv
// Top level of the run-length bitmap blitter with alpha blending.
//
// Input items enter through push/full; an item is taken at a clock edge with
// push high and full low. Each item gives exactly one result item, which
// appears on the out_ ports while empty is low and leaves on a clock edge with
// pop high. Item kinds: start a new image, one text character of the encoded
// image, or a pixel step that carries the background color for blending.
// Configuration goes through the cfg_ port, which is always ready; it should
// be written only while no item is in flight.
// Each item passes the middle queue and the blend register, then its result
// shows (empty low). Throughput is one item per cycle while full is low; the
// front-end parser and position tracker update as an item is taken; the blend
// stage (three channel multiply pairs, a divide by 255 in adders) keeps pace.
// If the receiver stalls, up to four results wait in the output queue and
// four more in the queue between front and back end; full then rises.
// A synchronous reset (rst_n low) empties both queues, returns the parser to
// its start state and sets width and height to 1 and the origin to 0.
`include "hex_rle_bitmap_blitter_defines.svh"
module hex_rle_bitmap_blitter
  import hrb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_text_char,
  input  logic [23:0]         in_background,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          out_status,
  output logic                out_write_enable,
  output logic [COORD_W-1:0]  out_pixel_x,
  output logic [COORD_W-1:0]  out_pixel_y,
  output logic [31:0]         out_pixel_color,
  output logic                out_run_pending,
  output logic [COORD_W-1:0]  out_next_x,
  output logic [COORD_W-1:0]  out_next_y,
  output logic                out_next_needs_background,
  output logic                out_done_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);

  cfg_t       cfg_r;
  logic       in_accept;
  front_rec_t front_rec;
  front_rec_t mid_data;
  logic       mid_full, mid_empty, mid_pop;
  result_t    res;
  logic       res_nonpixel, res_quiet;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= 13'd1;
      cfg_r.height   <= 13'd1;
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:    cfg_r.width    <= cfg_data;
        CFG_HEIGHT:   cfg_r.height   <= cfg_data;
        CFG_ORIGIN_X: cfg_r.origin_x <= cfg_data[11:0];
        CFG_ORIGIN_Y: cfg_r.origin_y <= cfg_data[11:0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  // An item is taken whenever the middle queue has room; the front end
  // classifies it and updates the parser state in the same cycle.
  assign full      = mid_full;
  assign in_accept = push && !mid_full;

  hrb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (in_accept),
    .kind       (in_kind),
    .text_char  (in_text_char),
    .background (in_background),
    .rec        (front_rec)
  );

  hrb_mid_queue u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept),
    .wr_data (front_rec),
    .q_full  (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_data),
    .q_empty (mid_empty)
  );

  hrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_data  (mid_data),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_status                = res.status;
  assign out_write_enable          = res.write_enable;
  assign out_pixel_x               = res.pixel_x;
  assign out_pixel_y               = res.pixel_y;
  assign out_pixel_color           = res.pixel_color;
  assign out_run_pending           = res.run_pending;
  assign out_next_x                = res.next_x;
  assign out_next_y                = res.next_y;
  assign out_next_needs_background = res.next_needs_background;
  assign out_done_res              = res.done_res;

  assign res_nonpixel = !empty && (out_status != ST_PIXEL);
  assign res_quiet    = !out_write_enable && (out_pixel_color == '0);

  // The back end never pops an empty middle queue.
  `HRB_ASSERT_SAME(a_pop_nonempty, clk, rst_n, mid_pop, !mid_empty)
  // An item taken by the blend stage passes its stage register into the result queue.
  `HRB_ASSERT_NEXT(a_pop_reaches_out, clk, rst_n, mid_pop, ##1 !empty)
  // Only an emitted pixel may carry a write or a color.
  `HRB_ASSERT_SAME(a_quiet_nonpixel, clk, rst_n, res_nonpixel, res_quiet)

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the run-length bitmap blitter with alpha blending.
`timescale 1ns / 100ps
module tb_top;
  import hrb_pkg::*;

  // The run stops here even if results are still missing. It is far above the
  // slowest correct run: about 500 items, each one waiting out both idle
  // settings and the blend pipeline, plus the drains before register writes.
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [7:0] TEXT_END     = 8'h00;
  localparam logic [7:0] RUN_MARK     = 8'h7E;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {SCAN_TOKEN, SCAN_COUNT, SCAN_COLOR} scan_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_kind = KIND_START;
  logic [7:0]  in_text_char = 8'h00;
  logic [23:0] in_background = 24'h000000;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_status;
  logic        out_write_enable;
  logic [COORD_W-1:0] out_pixel_x;
  logic [COORD_W-1:0] out_pixel_y;
  logic [31:0] out_pixel_color;
  logic        out_run_pending;
  logic [COORD_W-1:0] out_next_x;
  logic [COORD_W-1:0] out_next_y;
  logic        out_next_needs_background;
  logic        out_done_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [12:0] cfg_data = 13'd0;

  hex_rle_bitmap_blitter uut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .push                      (push),
    .full                      (full),
    .in_kind                   (in_kind),
    .in_text_char              (in_text_char),
    .in_background             (in_background),
    .empty                     (empty),
    .pop                       (pop),
    .out_status                (out_status),
    .out_write_enable          (out_write_enable),
    .out_pixel_x               (out_pixel_x),
    .out_pixel_y               (out_pixel_y),
    .out_pixel_color           (out_pixel_color),
    .out_run_pending           (out_run_pending),
    .out_next_x                (out_next_x),
    .out_next_y                (out_next_y),
    .out_next_needs_background (out_next_needs_background),
    .out_done_res              (out_done_res),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data)
  );

  always #4 clk = ~clk;

  // Results the block owes us, oldest first, and the run's bookkeeping.
  result_t due_results[$];
  int      items_sent = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  // Idle odds in percent for the sender and the receiver; each random phase sets them.
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  // Our own copy of the registers and of the decoder state.
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [11:0] origin_x_reg;
  logic [11:0] origin_y_reg;

  scan_phase_t scan_phase;
  int          digit_count;
  logic [31:0] color_acc;
  logic [7:0]  count_acc;
  logic        count_halt;
  logic [31:0] run_color;
  logic [7:0]  run_left;
  logic [11:0] col_idx;
  logic [12:0] row_idx;
  logic        img_done;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    scan_phase  = SCAN_TOKEN;
    digit_count = 0;
    color_acc   = '0;
    count_acc   = 8'd1;
    count_halt  = 1'b0;
    run_color   = '0;
    run_left    = '0;
    col_idx     = '0;
    row_idx     = '0;
    img_done    = 1'b0;
  endfunction

  // A width or height of 0 behaves as 1, anything above the maximum as the maximum.
  function automatic int unsigned side_used(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // Pixels still to be written before the image is full.
  function automatic int unsigned image_room();
    int unsigned w;
    int unsigned total;
    int unsigned pos;
    w = side_used(width_reg);
    total = w * side_used(height_reg);
    pos = row_idx * w + col_idx;
    return (pos >= total) ? 0 : total - pos;
  endfunction

  // Returns 16 for anything that is not a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'd16;
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg, logic [7:0] a);
    int unsigned sum;
    sum = int'(fg) * int'(a) + int'(bg) * (255 - int'(a));
    return 8'(sum / 255);
  endfunction

  // One accepted text character.
  function automatic void take_text(logic [7:0] c);
    logic [4:0]  v;
    int unsigned room;
    v = hex_value(c);
    if (c == TEXT_END) begin
      // The terminator throws away any half-read token and closes the image.
      scan_phase  = SCAN_TOKEN;
      digit_count = 0;
      color_acc   = '0;
      count_acc   = 8'd1;
      count_halt  = 1'b0;
      img_done    = 1'b1;
      return;
    end
    if (scan_phase == SCAN_TOKEN) begin
      if (c == RUN_MARK) begin
        scan_phase  = SCAN_COUNT;
        digit_count = 0;
        count_acc   = '0;
        count_halt  = 1'b0;
        return;
      end
      // No run mark: this character is already the first color digit.
      count_acc   = 8'd1;
      scan_phase  = SCAN_COLOR;
      digit_count = 0;
      color_acc   = '0;
    end
    if (scan_phase == SCAN_COUNT) begin
      if (!count_halt && v < 16) count_acc = {count_acc[3:0], v[3:0]};
      else count_halt = 1'b1;
      digit_count++;
      if (digit_count >= 2) begin
        scan_phase  = SCAN_COLOR;
        digit_count = 0;
        color_acc   = '0;
      end
      return;
    end
    color_acc = {color_acc[27:0], (v < 16) ? v[3:0] : 4'h0};
    digit_count++;
    if (digit_count >= 8) begin
      room      = image_room();
      run_color = color_acc;
      run_left  = (count_acc < room) ? count_acc : 8'(room);
      if (room == 0) img_done = 1'b1;
      scan_phase  = SCAN_TOKEN;
      digit_count = 0;
      color_acc   = '0;
      count_acc   = 8'd1;
      count_halt  = 1'b0;
    end
  endfunction

  // Advances the decoder by one item and returns the result it must give.
  function automatic result_t decode_and_blend(logic [1:0] kind, logic [7:0] ch,
                                               logic [23:0] bg);
    result_t     r;
    int unsigned w;
    logic [7:0]  a;
    r = '0;
    r.status = ST_REJECT;
    case (kind)
      KIND_START: begin
        clear_decoder();
        r.status = ST_STARTED;
      end
      KIND_CHAR: begin
        if (!img_done && run_left == 0) begin
          take_text(ch);
          r.status = ST_CHAR;
        end
      end
      KIND_STEP: begin
        if (run_left != 0) begin
          w = side_used(width_reg);
          a = run_color[31:24];
          r.status  = ST_PIXEL;
          r.pixel_x = origin_x_reg + col_idx;
          r.pixel_y = origin_y_reg + row_idx;
          if (a == ALPHA_OPAQUE) begin
            r.write_enable = 1'b1;
            r.pixel_color  = run_color;
          end else if (a != ALPHA_CLEAR) begin
            r.write_enable = 1'b1;
            r.pixel_color  = {ALPHA_OPAQUE,
                              mix_channel(run_color[23:16], bg[23:16], a),
                              mix_channel(run_color[15:8], bg[15:8], a),
                              mix_channel(run_color[7:0], bg[7:0], a)};
          end
          // A column already past a shrunken width still wraps after this pixel.
          if (col_idx + 1 >= w) begin
            col_idx = '0;
            row_idx = row_idx + 1'b1;
          end else begin
            col_idx = col_idx + 1'b1;
          end
          run_left = run_left - 1'b1;
          if (run_left == 0 && image_room() == 0) img_done = 1'b1;
        end
      end
      default: ;
    endcase
    a = run_color[31:24];
    r.run_pending = (run_left != 0);
    r.next_x      = origin_x_reg + col_idx;
    r.next_y      = origin_y_reg + row_idx;
    r.next_needs_background = (run_left != 0) && a != ALPHA_CLEAR && a != ALPHA_OPAQUE;
    r.done_res    = img_done;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0h", $time, out_status);
      mismatch_count++;
    end else begin
      want = due_results.pop_front();
      compare_field("status", want.status, out_status);
      compare_field("write_enable", want.write_enable, out_write_enable);
      compare_field("pixel_x", want.pixel_x, out_pixel_x);
      compare_field("pixel_y", want.pixel_y, out_pixel_y);
      compare_field("pixel_color", want.pixel_color, out_pixel_color);
      compare_field("run_pending", want.run_pending, out_run_pending);
      compare_field("next_x", want.next_x, out_next_x);
      compare_field("next_y", want.next_y, out_next_y);
      compare_field("next_needs_background", want.next_needs_background,
                    out_next_needs_background);
      compare_field("done_res", want.done_res, out_done_res);
    end
  endtask

  // The receiver: a result leaves at an edge where pop is high and empty is
  // low. Outputs are sampled right at the edge, before the block updates them,
  // and pop for the next edge is chosen at random from the stall odds.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one item and returns at the edge where the block takes it. Push is
  // left high, so that the next item follows without a gap unless the sender
  // chooses to idle; the expected result is recorded at acceptance.
  task automatic send_item(logic [1:0] kind, logic [7:0] ch, logic [23:0] bg);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_kind       <= kind;
    in_text_char  <= ch;
    in_background <= bg;
    @(posedge clk);
    while (full) @(posedge clk);
    due_results.push_back(decode_and_blend(kind, ch, bg));
    items_sent++;
  endtask

  task automatic send_start();
    send_item(KIND_START, 8'($urandom), 24'($urandom));
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(KIND_CHAR, c, 24'($urandom));
  endtask

  task automatic send_step(logic [23:0] bg);
    send_item(KIND_STEP, 8'($urandom), bg);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Lets every result come home with the sender quiet.
  task automatic wait_until_drained();
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WIDTH:    width_reg = value;
      CFG_HEIGHT:   height_reg = value;
      CFG_ORIGIN_X: origin_x_reg = value[11:0];
      CFG_ORIGIN_Y: origin_y_reg = value[11:0];
      default: ;
    endcase
  endtask

  // Registers change only with nothing in flight, so the block is drained first.
  task automatic write_registers(logic [12:0] w, logic [12:0] h, logic [12:0] ox,
                                 logic [12:0] oy, logic [3:0] which);
    wait_until_drained();
    if (which[CFG_WIDTH]) reg_write(CFG_WIDTH, w);
    if (which[CFG_HEIGHT]) reg_write(CFG_HEIGHT, h);
    if (which[CFG_ORIGIN_X]) reg_write(CFG_ORIGIN_X, ox);
    if (which[CFG_ORIGIN_Y]) reg_write(CFG_ORIGIN_Y, oy);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
  endfunction

  // Mostly small images so that runs reach the end of the image often.
  function automatic logic [12:0] pick_side();
    case ($urandom_range(9))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom_range(8191, 4097));
      default: return 13'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic logic [12:0] pick_origin();
    case ($urandom_range(5))
      0: return 13'd0;
      1: return 13'd4095;
      default: return 13'($urandom);
    endcase
  endfunction

  // A token with random content, now and then with a broken digit.
  task automatic send_random_token();
    logic [31:0] argb;
    logic [7:0]  cnt;
    logic [7:0]  c;
    case ($urandom_range(9))
      0, 1:    argb[31:24] = ALPHA_CLEAR;
      2, 3, 4: argb[31:24] = ALPHA_OPAQUE;
      default: argb[31:24] = 8'($urandom_range(254, 1));
    endcase
    argb[23:0] = 24'($urandom);
    if ($urandom_range(3) != 0) begin
      send_char(RUN_MARK);
      cnt = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(9));
      for (int k = 0; k < 2; k++) begin
        c = hex_char(k == 0 ? cnt[7:4] : cnt[3:0]);
        if ($urandom_range(14) == 0) c = 8'($urandom_range(255, 1));
        send_char(c);
      end
    end
    for (int k = 0; k < 8; k++) begin
      c = hex_char(argb[31 - 4 * k -: 4]);
      if ($urandom_range(24) == 0) c = 8'($urandom_range(255, 1));
      send_char(c);
    end
  endtask

  // Emits the pending run, sometimes poking it with a character that must be
  // refused or with one step too many.
  task automatic send_run_steps();
    int n;
    if ($urandom_range(11) == 0) send_char(8'($urandom));
    n = run_left;
    for (int i = 0; i < n; i++) send_step(24'($urandom));
    if ($urandom_range(11) == 0) send_step(24'($urandom));
  endtask

  // One stretch of random traffic under fresh register settings.
  task automatic run_random_phase(int send_pct, int recv_pct, int count);
    int target;
    int pick;
    write_registers(pick_side(), pick_side(), pick_origin(), pick_origin(), 4'b1111);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    send_start();
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_start();
      end else if (pick < 6) begin
        send_char(TEXT_END);
      end else if (pick < 10) begin
        send_item(2'($urandom), 8'($urandom), 24'($urandom));
      end else if (pick < 12) begin
        // Width changes in the middle of an image.
        write_registers(pick_side(), '0, '0, '0, 4'b0001);
      end else begin
        send_random_token();
        send_run_steps();
      end
      if (img_done && $urandom_range(3) != 0) send_start();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Refused items, blending against both background extremes, a skipped pixel,
  // the image filling up, count and color digits that are not hex, and the
  // terminator in the middle of a token. The 2x2 image sits at the far corner
  // of the screen so the emitted coordinates carry into bit 12.
  task automatic test_rejects_and_blending();
    write_registers(13'd2, 13'd2, 13'd4095, 13'd4095, 4'b1111);
    send_step(24'hFFFFFF);
    send_item(KIND_UNUSED, 8'hFF, 24'hFFFFFF);
    send_start();
    send_text("~3z");
    send_text("80Gf00FF");
    send_char("A");
    send_step(24'h000000);
    send_step(24'hFFFFFF);
    send_step(24'($urandom));
    send_text("00123456");
    send_step(24'h5A5A5A);
    send_char("1");
    send_start();
    send_text("ffABCDEF");
    send_step(24'h000000);
    send_text("~1");
    send_char(TEXT_END);
    send_step(24'h000000);
  endtask

  // Width and height at 0 and far above the maximum, origin writes with bit 12
  // set, and a run clipped to a one-pixel image.
  task automatic test_size_extremes();
    write_registers(13'd0, 13'd0, 13'd0, 13'd0, 4'b1111);
    send_start();
    send_text("~05FF010203");
    send_step(24'h000000);
    write_registers(13'd8191, 13'd8191, 13'h1FFF, 13'h1FFF, 4'b1111);
    send_start();
    send_text("~037Fabcdef");
    for (int i = 0; i < 3; i++) send_step(24'($urandom));
  endtask

  // The width shrinks below the current column, then the height shrinks below
  // the current row, so the next token finds the image already over.
  task automatic test_resize_mid_image();
    write_registers(13'd8, 13'd2, 13'd10, 13'd20, 4'b1111);
    send_start();
    send_text("~05FF112233");
    for (int i = 0; i < 5; i++) send_step(24'($urandom));
    write_registers(13'd3, '0, '0, '0, 4'b0001);
    send_text("FF445566");
    send_step(24'($urandom));
    write_registers('0, 13'd1, '0, '0, 4'b0010);
    send_text("~02FFaabbcc");
    send_step(24'($urandom));
  endtask

  // Random traffic under each pairing of sender and receiver idling.
  task automatic test_random_traffic();
    run_random_phase(0, 0, 75);
    run_random_phase(74, 0, 75);
    run_random_phase(0, 74, 75);
    run_random_phase(17, 17, 75);
  endtask

  initial begin
    width_reg    = 13'd1;
    height_reg   = 13'd1;
    origin_x_reg = '0;
    origin_y_reg = '0;
    clear_decoder();

    // Synchronous reset at the start of the run, never asserted again.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_rejects_and_blending();
    test_size_extremes();
    test_resize_mid_image();
    test_random_traffic();

    // Everything sent: wait for the last results, then keep the clock running so a
    // stray extra result would still be caught by the receiver.
    wait_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
